[rtl/core/lidar_packet_to_points_assert.svh]
// Assertion macros for the lidar point decoder RTL, used by lpp_ctrl.
// Needs clk and arst_n in the scope of each use.
`ifndef LIDAR_PACKET_TO_POINTS_ASSERT_SVH
`define LIDAR_PACKET_TO_POINTS_ASSERT_SVH

// same-cycle implication
`define LPP_ASSERT_NOW(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("lpp assertion failed");

// next-cycle implication
`define LPP_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("lpp assertion failed");

`endif

[rtl/core/lpp_pkg.sv]
// Shared constants, types and tables of the lidar point decoder.
// No dependencies.
package lpp_pkg;

	localparam int NUM_LASERS        = 64;
	localparam int PACKET_BYTES      = 1206;
	localparam int BLOCKS_PER_PACKET = 12;
	localparam int RETURNS_PER_BLOCK = 32;
	localparam int BLOCK_STRIDE      = 100;
	localparam int BLOCK_LIMIT       = 12;
	localparam int CAL_DEPTH         = 64;
	localparam int CAL_W             = 59;

	localparam logic [15:0] HDR_UPPER = 16'hEEFF;
	localparam logic [15:0] HDR_LOWER = 16'hDDFF;

	localparam int FULL_TURN    = 36000;
	localparam int HALF_TURN    = 18000;
	localparam int QUARTER_TURN = 9000;

	localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

	localparam logic [15:0] RANGE_MIN_RESET = 16'd1100;
	localparam logic [15:0] RANGE_MAX_RESET = 16'd60000;

	localparam logic REG_RANGE_MIN = 1'b0;
	localparam logic REG_RANGE_MAX = 1'b1;

	localparam logic [1:0] ANG_CT = 2'd0;
	localparam logic [1:0] ANG_TH = 2'd1;
	localparam logic [1:0] ANG_PH = 2'd2;

	typedef struct packed {
		logic signed [12:0] vert;
		logic signed [11:0] rot;
		logic signed [12:0] dcorr;
		logic signed [10:0] voff;
		logic signed [8:0]  hoff;
		logic               en;
	} cal_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_CINIT,
		S_CITER,
		S_CSAVE,
		S_MUL1,
		S_MUL2,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       byte_take;
		logic       cal_take;
		logic       check;
		logic       cinit;
		logic       citer;
		logic       csave;
		logic       mul1;
		logic       mul2;
		logic       emit;
		logic [1:0] ang;
		logic [3:0] step;
	} cmd_t;

	typedef struct packed {
		logic ret_last;
		logic point_ok;
		logic out_full;
		logic out_take;
	} status_t;

	function automatic logic signed [24:0] atan_units(input logic [3:0] i);
		logic signed [24:0] v;
		unique case (i)
			4'd0:  v = 25'sd1152000;
			4'd1:  v = 25'sd680065;
			4'd2:  v = 25'sd359328;
			4'd3:  v = 25'sd182400;
			4'd4:  v = 25'sd91554;
			4'd5:  v = 25'sd45822;
			4'd6:  v = 25'sd22916;
			4'd7:  v = 25'sd11459;
			4'd8:  v = 25'sd5730;
			4'd9:  v = 25'sd2865;
			4'd10: v = 25'sd1432;
			4'd11: v = 25'sd716;
			4'd12: v = 25'sd358;
			4'd13: v = 25'sd179;
			4'd14: v = 25'sd90;
			4'd15: v = 25'sd45;
		endcase
		return v;
	endfunction

	function automatic logic signed [24:0] round_mm(input logic signed [53:0] v);
		logic signed [53:0] t;
		t = (v + 54'sd536870912) >>> 30;
		return t[24:0];
	endfunction

	function automatic logic signed [18:0] sat19(input logic signed [24:0] v);
		logic signed [18:0] r;
		if (v > 25'sd262143)
			r = 19'sd262143;
		else if (v < -25'sd262144)
			r = -19'sd262144;
		else
			r = v[18:0];
		return r;
	endfunction

endpackage

[rtl/core/lpp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/lpp_datapath.sv]
// Datapath of the lidar point decoder: byte parser, calibration store,
// shared CORDIC unit, correction multipliers and output register. Uses lpp_pkg, lpp_ram.
module lpp_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lpp_pkg::cmd_t          cmd,
	output lpp_pkg::status_t       status,
	input  logic                   wr_en,
	input  logic                   wr_index,
	input  logic [15:0]            wr_data,
	input  logic [7:0]             data_byte,
	input  logic                   first_of_packet,
	input  logic [5:0]             laser_index,
	input  logic signed [12:0]     vert_angle_cdeg,
	input  logic signed [11:0]     rot_corr_cdeg,
	input  logic signed [12:0]     dist_corr_mm,
	input  logic signed [10:0]     vert_offset_mm,
	input  logic signed [8:0]      horiz_offset_mm,
	input  logic                   laser_enable,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic signed [18:0]     coord_forward_mm,
	output logic signed [18:0]     coord_up_mm,
	output logic signed [18:0]     coord_back_mm,
	output logic [5:0]             laser_number,
	output logic [7:0]             return_intensity
);
	import lpp_pkg::*;

	logic [15:0] range_min_q, range_max_q;
	logic [10:0] pos_q, pos_c;
	logic [6:0]  off_q, off_c;
	logic [3:0]  blk_q, blk_c;
	logic [1:0]  rk_q, rk_c;
	logic [5:0]  rr_q, rr_c;
	logic        in_pkt, in_blk, is_ret;
	logic [15:0] partial_q, rot_q;
	logic        upper_q;
	logic [15:0] raw_q;
	logic [7:0]  inten_q;
	logic [5:0]  laser_q, rd_laser;
	cal_t        cal_wr, cal_rd;

	logic signed [18:0] d_q;
	logic signed [8:0]  h_q;
	logic signed [10:0] v_q;
	logic [15:0]        ang_ct_q, ang_th_q, ang_ph_q;
	logic [16:0]        rot_m;
	logic [15:0]        ct_c, th_c, ph_c;
	logic signed [17:0] th_s, ph_s;

	logic [15:0]        ang_sel;
	logic signed [17:0] a_s, a_f;
	logic               flip_c, flip_q;
	logic signed [32:0] x_q, y_q, xs, ys;
	logic signed [24:0] z_q;
	logic signed [17:0] xr, yr;
	logic signed [16:0] xc, yc, cos_v;
	logic signed [16:0] cct_q, sct_q, cth_q, sth_q, cph_q, sph_q;

	logic signed [35:0] pc_q, ps_q, pz_q;
	logic signed [25:0] hc_q, hs_q;
	logic signed [27:0] vc_q;
	logic signed [53:0] xa_q, ya_q, za_q;
	logic signed [24:0] y_rnd;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= RANGE_MIN_RESET;
			range_max_q <= RANGE_MAX_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RANGE_MIN: range_min_q <= wr_data;
				REG_RANGE_MAX: range_max_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		pos_c  = first_of_packet ? '0 : pos_q;
		off_c  = first_of_packet ? '0 : off_q;
		blk_c  = first_of_packet ? '0 : blk_q;
		rk_c   = first_of_packet ? '0 : rk_q;
		rr_c   = first_of_packet ? '0 : rr_q;
		in_pkt = pos_c < 11'(PACKET_BYTES);
		in_blk = (pos_c < 11'(BLOCK_STRIDE * BLOCK_LIMIT)) &&
			(blk_c < 4'(BLOCKS_PER_PACKET));
		is_ret = (off_c >= 7'd4) && (rr_c < 6'(RETURNS_PER_BLOCK));
		rd_laser = {~upper_q, rr_c[4:0]};
	end

	assign status.ret_last = in_pkt && in_blk && is_ret && (rk_c == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			off_q     <= '0;
			blk_q     <= '0;
			rk_q      <= '0;
			rr_q      <= '0;
			partial_q <= '0;
			upper_q   <= 1'b0;
			rot_q     <= '0;
		end else if (cmd.byte_take && in_pkt) begin
			pos_q <= pos_c + 11'd1;
			if (off_c == 7'(BLOCK_STRIDE - 1)) begin
				off_q <= '0;
				blk_q <= blk_c + 4'd1;
			end else begin
				off_q <= off_c + 7'd1;
				blk_q <= blk_c;
			end
			if (off_c <= 7'd3 || off_c == 7'(BLOCK_STRIDE - 1)) begin
				rk_q <= '0;
				rr_q <= '0;
			end else if (rk_c == 2'd2) begin
				rk_q <= '0;
				rr_q <= rr_c + 6'd1;
			end else begin
				rk_q <= rk_c + 2'd1;
				rr_q <= rr_c;
			end
			if (in_blk) begin
				if (off_c == 7'd0 || off_c == 7'd2) begin
					partial_q <= {8'd0, data_byte};
				end else if (off_c == 7'd1) begin
					if ({data_byte, partial_q[7:0]} == HDR_UPPER)
						upper_q <= 1'b1;
					else if ({data_byte, partial_q[7:0]} == HDR_LOWER)
						upper_q <= 1'b0;
				end else if (off_c == 7'd3) begin
					rot_q <= {data_byte, partial_q[7:0]};
				end else if (is_ret && rk_c == 2'd0) begin
					partial_q <= {8'd0, data_byte};
				end else if (is_ret && rk_c == 2'd1) begin
					partial_q <= {data_byte, partial_q[7:0]};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_take && status.ret_last) begin
			raw_q   <= partial_q;
			inten_q <= data_byte;
			laser_q <= rd_laser;
		end
	end

	always_comb begin
		cal_wr.vert  = vert_angle_cdeg;
		cal_wr.rot   = rot_corr_cdeg;
		cal_wr.dcorr = dist_corr_mm;
		cal_wr.voff  = vert_offset_mm;
		cal_wr.hoff  = horiz_offset_mm;
		cal_wr.en    = laser_enable;
	end

	lpp_ram #(
		.WIDTH(CAL_W),
		.DEPTH(CAL_DEPTH)
	) u_cal_ram (
		.clk   (clk),
		.we    (cmd.cal_take),
		.waddr (laser_index),
		.wdata (cal_wr),
		.re    (cmd.byte_take && status.ret_last),
		.raddr (rd_laser),
		.rdata (cal_rd)
	);

	assign status.point_ok = (raw_q > range_min_q) && (raw_q < range_max_q) && cal_rd.en &&
		({1'b0, laser_q} < 7'(NUM_LASERS));

	always_comb begin
		rot_m = (rot_q >= 16'(FULL_TURN)) ? 17'(rot_q) - 17'(FULL_TURN) : 17'(rot_q);
		ct_c  = (rot_m == '0) ? '0 : 16'(17'(FULL_TURN) - rot_m);
		th_s  = $signed({2'b00, ct_c}) + 18'(cal_rd.rot);
		if (th_s < 18'sd0)
			th_c = 16'(th_s + 18'(FULL_TURN));
		else if (th_s >= 18'(FULL_TURN))
			th_c = 16'(th_s - 18'(FULL_TURN));
		else
			th_c = 16'(th_s);
		ph_s = 18'(cal_rd.vert);
		ph_c = (ph_s < 18'sd0) ? 16'(ph_s + 18'(FULL_TURN)) : 16'(ph_s);
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			d_q      <= 19'($signed({1'b0, raw_q, 1'b0})) + 19'(cal_rd.dcorr);
			h_q      <= cal_rd.hoff;
			v_q      <= cal_rd.voff;
			ang_ct_q <= ct_c;
			ang_th_q <= th_c;
			ang_ph_q <= ph_c;
		end
	end

	always_comb begin
		unique case (cmd.ang)
			ANG_CT:  ang_sel = ang_ct_q;
			ANG_TH:  ang_sel = ang_th_q;
			ANG_PH:  ang_sel = ang_ph_q;
			default: ang_sel = ang_ph_q;
		endcase
		a_s = (ang_sel >= 16'(HALF_TURN)) ? $signed({2'b00, ang_sel}) - 18'(FULL_TURN) :
			$signed({2'b00, ang_sel});
		if (a_s > 18'(QUARTER_TURN)) begin
			a_f    = 18'(HALF_TURN) - a_s;
			flip_c = 1'b1;
		end else if (a_s < -18'(QUARTER_TURN)) begin
			a_f    = -18'(HALF_TURN) - a_s;
			flip_c = 1'b1;
		end else begin
			a_f    = a_s;
			flip_c = 1'b0;
		end
		xs = x_q >>> cmd.step;
		ys = y_q >>> cmd.step;
		xr = 18'((x_q + 33'sd16384) >>> 15);
		yr = 18'((y_q + 33'sd16384) >>> 15);
		if (xr > 18'sd32768)
			xc = 17'sd32768;
		else if (xr < -18'sd32768)
			xc = -17'sd32768;
		else
			xc = xr[16:0];
		if (yr > 18'sd32768)
			yc = 17'sd32768;
		else if (yr < -18'sd32768)
			yc = -17'sd32768;
		else
			yc = yr[16:0];
		cos_v = flip_q ? -xc : xc;
	end

	always_ff @(posedge clk) begin
		if (cmd.cinit) begin
			x_q    <= CORDIC_START;
			y_q    <= '0;
			z_q    <= 25'(a_f) <<< 8;
			flip_q <= flip_c;
		end else if (cmd.citer) begin
			if (z_q >= 25'sd0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_units(cmd.step);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_units(cmd.step);
			end
		end
		if (cmd.csave) begin
			unique case (cmd.ang)
				ANG_CT: begin
					cct_q <= cos_v;
					sct_q <= yc;
				end
				ANG_TH: begin
					cth_q <= cos_v;
					sth_q <= yc;
				end
				ANG_PH: begin
					cph_q <= cos_v;
					sph_q <= yc;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			pc_q <= 36'(d_q) * 36'(cth_q);
			ps_q <= 36'(d_q) * 36'(sth_q);
			pz_q <= 36'(d_q) * 36'(sph_q);
			hc_q <= 26'(h_q) * 26'(cct_q);
			hs_q <= 26'(h_q) * 26'(sct_q);
			vc_q <= 28'(v_q) * 28'(cph_q);
		end
		if (cmd.mul2) begin
			xa_q <= 54'(pc_q) * 54'(cph_q) - (54'(hc_q) <<< 15);
			ya_q <= 54'(ps_q) * 54'(cph_q) - (54'(hs_q) <<< 15);
			za_q <= (54'(pz_q) <<< 15) + (54'(vc_q) <<< 15);
		end
	end

	assign y_rnd = round_mm(ya_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			coord_forward_mm <= sat19(round_mm(xa_q));
			coord_up_mm      <= sat19(round_mm(za_q));
			coord_back_mm    <= sat19(-y_rnd);
			laser_number     <= laser_q;
			return_intensity <= inten_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid       = out_valid_q;
	assign status.out_full = out_valid_q;
	assign status.out_take = out_valid_q && !out_stall;

endmodule

[rtl/core/lpp_ctrl.sv]
// Controller of the lidar point decoder: sequences word intake, CORDIC runs,
// multiplies and result handoff. Uses lpp_pkg and the assertion macro header.
`include "lidar_packet_to_points_assert.svh"

module lpp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             kind,
	output logic             in_stall,
	input  lpp_pkg::status_t status,
	output lpp_pkg::cmd_t    cmd
);
	import lpp_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] ang_q, ang_d;
	logic [3:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ang_q   <= ANG_CT;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			ang_q   <= ang_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ang_d    = ang_q;
		step_d   = step_q;
		cmd      = '0;
		cmd.ang  = ang_q;
		cmd.step = step_q;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (kind) begin
						cmd.cal_take = 1'b1;
					end else begin
						cmd.byte_take = 1'b1;
						if (status.ret_last)
							state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				ang_d     = ANG_CT;
				state_d   = status.point_ok ? S_CINIT : S_IDLE;
			end
			S_CINIT: begin
				cmd.cinit = 1'b1;
				step_d    = '0;
				state_d   = S_CITER;
			end
			S_CITER: begin
				cmd.citer = 1'b1;
				step_d    = step_q + 4'd1;
				if (step_q == '1)
					state_d = S_CSAVE;
			end
			S_CSAVE: begin
				cmd.csave = 1'b1;
				if (ang_q == ANG_PH) begin
					state_d = S_MUL1;
				end else begin
					ang_d   = ang_q + 2'd1;
					state_d = S_CINIT;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!status.out_full || status.out_take) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`LPP_ASSERT_NOW(a_emit_room, cmd.emit, !status.out_full || status.out_take)
	`LPP_ASSERT_NEXT(a_iter_len, state_q == S_CITER && step_q == 4'd15, state_q == S_CSAVE)
	`LPP_ASSERT_NEXT(a_three_runs, state_q == S_CSAVE && ang_q == ANG_PH, state_q == S_MUL1)
	`LPP_ASSERT_NOW(a_busy_stall, state_q != S_IDLE, in_stall && !cmd.byte_take && !cmd.cal_take)

endmodule

[rtl/core/lidar_packet_to_points.sv]
// Channel  | Dir | Handshake          | Word
// in       | in  | in_valid/in_stall  | kind, data_byte, first_of_packet, calibration fields
// out      | out | out_valid/out_stall| three coordinates, laser_number, return_intensity
// cfg      | in  | wr_en              | wr_index, wr_data
// Payload and calibration words are accepted while the controller is idle. The last byte
// of a return stalls the input for the range and enable check (S_CHECK) and, when the
// return passes, for the one shared 16-step CORDIC unit run for three angles, the
// multiply states S_MUL1, S_MUL2 and the output load, held while the output is full.
// The output register lets the next words enter while a point waits on out_stall.
// Reset (arst_n low, asynchronous) clears parser, bank, rotation; presets range limits.
// Top level of the lidar point decoder. Uses lpp_pkg, lpp_ctrl, lpp_datapath.
module lidar_packet_to_points (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [7:0]         data_byte,
	input  logic               first_of_packet,
	input  logic [5:0]         laser_index,
	input  logic signed [12:0] vert_angle_cdeg,
	input  logic signed [11:0] rot_corr_cdeg,
	input  logic signed [12:0] dist_corr_mm,
	input  logic signed [10:0] vert_offset_mm,
	input  logic signed [8:0]  horiz_offset_mm,
	input  logic               laser_enable,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [18:0] coord_forward_mm,
	output logic signed [18:0] coord_up_mm,
	output logic signed [18:0] coord_back_mm,
	output logic [5:0]         laser_number,
	output logic [7:0]         return_intensity,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [15:0]        wr_data
);
	import lpp_pkg::*;

	cmd_t    cmd;
	status_t status;

	lpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lpp_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.data_byte        (data_byte),
		.first_of_packet  (first_of_packet),
		.laser_index      (laser_index),
		.vert_angle_cdeg  (vert_angle_cdeg),
		.rot_corr_cdeg    (rot_corr_cdeg),
		.dist_corr_mm     (dist_corr_mm),
		.vert_offset_mm   (vert_offset_mm),
		.horiz_offset_mm  (horiz_offset_mm),
		.laser_enable     (laser_enable),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.coord_forward_mm (coord_forward_mm),
		.coord_up_mm      (coord_up_mm),
		.coord_back_mm    (coord_back_mm),
		.laser_number     (laser_number),
		.return_intensity (return_intensity)
	);

endmodule

[verif/tb.sv]
// Self-checking bench for lidar_packet_to_points: calibration and packet words in, points out.
// Predicts each point with a local CORDIC and Q30 arithmetic; depends on lpp_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
	import lpp_pkg::*;

	typedef struct {
		logic               kind;
		logic [7:0]         data_byte;
		logic               first;
		logic [5:0]         idx;
		logic signed [12:0] vert;
		logic signed [11:0] rot;
		logic signed [12:0] dcorr;
		logic signed [10:0] voff;
		logic signed [8:0]  hoff;
		logic               en;
	} word_t;

	typedef struct {
		logic signed [18:0] fwd;
		logic signed [18:0] up;
		logic signed [18:0] back;
		logic [5:0]         laser;
		logic [7:0]         inten;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [7:0] data_byte = 8'd0;
	logic first_of_packet = 1'b0;
	logic [5:0] laser_index = 6'd0;
	logic signed [12:0] vert_angle_cdeg = '0;
	logic signed [11:0] rot_corr_cdeg = '0;
	logic signed [12:0] dist_corr_mm = '0;
	logic signed [10:0] vert_offset_mm = '0;
	logic signed [8:0] horiz_offset_mm = '0;
	logic laser_enable = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [18:0] coord_forward_mm, coord_up_mm, coord_back_mm;
	logic [5:0] laser_number;
	logic [7:0] return_intensity;
	logic wr_en = 1'b0;
	logic wr_index = REG_RANGE_MIN;
	logic [15:0] wr_data = 16'd0;

	lidar_packet_to_points i_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [15:0] pr_min, pr_max;
	logic signed [12:0] cal_vert [64];
	logic signed [11:0] cal_rot [64];
	logic signed [12:0] cal_dist [64];
	logic signed [10:0] cal_voff [64];
	logic signed [8:0]  cal_hoff [64];
	logic cal_en [64];
	int unsigned pos;
	bit bank_upper;
	logic [15:0] blk_rot, part;

	word_t pending [$];
	point_t points_due [$];
	int errors = 0, n_words = 0, n_points = 0;
	int drv_wait = 0, mon_wait = 0;
	bit hold_go = 0;
	bit hold_on = 0;
	bit run_done = 0;
	int idle_cycles = 0;

	function automatic longint asr_l(longint v, int s);
		return v >>> s;
	endfunction

	task automatic sincos(input int a, output longint s, output longint c);
		bit flip;
		longint x, y, z, nx, ny;
		flip = 0; x = 652032874; y = 0;
		if (a >= 18000) a -= 36000;
		if (a > 9000) begin a = 18000 - a; flip = 1; end
		else if (a < -9000) begin a = -18000 - a; flip = 1; end
		z = longint'(a) * 256;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - asr_l(y, i); ny = y + asr_l(x, i); z -= atan_units(i[3:0]);
			end else begin
				nx = x + asr_l(y, i); ny = y - asr_l(x, i); z += atan_units(i[3:0]);
			end
			x = nx; y = ny;
		end
		x = asr_l(x + 16384, 15); y = asr_l(y + 16384, 15);
		if (x > 32768) x = 32768;
		if (x < -32768) x = -32768;
		if (y > 32768) y = 32768;
		if (y < -32768) y = -32768;
		s = y; c = flip ? -x : x;
	endtask

	function automatic logic signed [18:0] clamp19(longint v);
		if (v > 262143) v = 262143;
		if (v < -262144) v = -262144;
		return v[18:0];
	endfunction

	task automatic predict_point(input int laser, input logic [15:0] raw, input logic [7:0] b);
		int ct, th;
		longint sct, cct, sth, cth, sph, cph, d, x, y, z;
		point_t p;
		if (!(raw > pr_min && raw < pr_max)) return;
		if (!cal_en[laser]) return;
		ct = (36000 - (blk_rot % 36000)) % 36000;
		th = (ct + cal_rot[laser] + 36000) % 36000;
		sincos(ct, sct, cct);
		sincos(th, sth, cth);
		sincos((cal_vert[laser] + 36000) % 36000, sph, cph);
		d = longint'(raw) * 2 + cal_dist[laser];
		x = d * cth * cph - longint'(cal_hoff[laser]) * cct * 32768;
		y = d * sth * cph - longint'(cal_hoff[laser]) * sct * 32768;
		z = d * sph * 32768 + longint'(cal_voff[laser]) * cph * 32768;
		x = (x + (64'sd1 << 29)) >>> 30;
		y = (y + (64'sd1 << 29)) >>> 30;
		z = (z + (64'sd1 << 29)) >>> 30;
		p.fwd = clamp19(x); p.up = clamp19(z); p.back = clamp19(-y);
		p.laser = laser[5:0]; p.inten = b;
		points_due = {points_due, p};
	endtask

	task automatic predict_word(input word_t w);
		int unsigned cur, off, r, k;
		logic [15:0] h;
		if (w.kind) begin
			cal_vert[w.idx] = w.vert; cal_rot[w.idx] = w.rot; cal_dist[w.idx] = w.dcorr;
			cal_voff[w.idx] = w.voff; cal_hoff[w.idx] = w.hoff; cal_en[w.idx] = w.en;
			return;
		end
		if (w.first) pos = 0;
		if (pos >= PACKET_BYTES) return;
		cur = pos++;
		if (cur >= 1200) return;
		off = cur % 100;
		if (off == 0 || off == 2) begin part = {8'd0, w.data_byte}; return; end
		if (off == 1) begin
			h = {w.data_byte, part[7:0]};
			if (h == HDR_UPPER) bank_upper = 1;
			else if (h == HDR_LOWER) bank_upper = 0;
			return;
		end
		if (off == 3) begin blk_rot = {w.data_byte, part[7:0]}; return; end
		r = (off - 4) / 3; k = (off - 4) % 3;
		if (k == 0) part = {8'd0, w.data_byte};
		else if (k == 1) part = {w.data_byte, part[7:0]};
		else predict_point((bank_upper ? 0 : 32) + r, part, w.data_byte);
	endtask

	function automatic word_t cal_word(int idx, bit rnd, bit en);
		word_t w;
		w.kind = 1'b1; w.data_byte = 8'($urandom); w.first = 1'($urandom); w.idx = 6'(idx);
		w.vert = 13'($urandom); w.rot = 12'($urandom); w.dcorr = 13'($urandom);
		w.voff = 11'($urandom); w.hoff = 9'($urandom); w.en = en;
		if (!rnd) begin
			w.vert = (idx % 2) ? -13'sd4096 : 13'sd4095;
			w.rot = (idx % 2) ? -12'sd2048 : 12'sd2047;
			w.dcorr = (idx % 2) ? -13'sd4096 : 13'sd4095;
			w.voff = (idx % 2) ? -11'sd1024 : 11'sd1023;
			w.hoff = (idx % 2) ? -9'sd256 : 9'sd255;
		end
		return w;
	endfunction

	function automatic word_t byte_word(logic [7:0] b, bit first);
		word_t w;
		w = cal_word($urandom_range(0, 63), 1'b1, 1'($urandom));
		w.kind = 1'b0; w.data_byte = b; w.first = first;
		return w;
	endfunction

	// one packet; nblk blocks carry content, then optional trailer / truncation
	task automatic queue_packet(int nblk, int nret, bit full_tail, bit extra);
		int total;
		total = 0;
		for (int bk = 0; bk < nblk; bk++) begin
			int hsel;
			logic [15:0] hdr, rot, raw;
			hsel = $urandom_range(0, 9);
			hdr = hsel < 5 ? HDR_UPPER : hsel < 9 ? HDR_LOWER : 16'($urandom);
			rot = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
			pending = {pending, byte_word(hdr[7:0], total == 0)}; total++;
			pending = {pending, byte_word(hdr[15:8], 1'b0)}; total++;
			pending = {pending, byte_word(rot[7:0], 1'b0)}; total++;
			pending = {pending, byte_word(rot[15:8], 1'b0)}; total++;
			for (int r = 0; r < 32; r++) begin
				if (r < nret) raw = ($urandom_range(0, 7) == 0) ? 16'($urandom)
					: 16'($urandom_range(1000, 61000));
				else raw = 16'd0;
				pending = {pending, byte_word(raw[7:0], 1'b0)}; total++;
				pending = {pending, byte_word(raw[15:8], 1'b0)}; total++;
				pending = {pending, byte_word(8'($urandom), 1'b0)}; total++;
			end
			if (!full_tail && bk == nblk - 1) return;
		end
		while (total < PACKET_BYTES + (extra ? 4 : 0)) begin
			pending = {pending, byte_word(8'($urandom), 1'b0)}; total++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				n_words++;
			if (!in_valid || !in_stall) begin
				if (drv_wait > 0) begin
					drv_wait <= drv_wait - 1;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					word_t w;
					w = pending.pop_front();
					predict_word(w);
					drv_wait <= $urandom_range(0, 4);
					in_valid <= 1'b1;
					kind <= w.kind; data_byte <= w.data_byte; first_of_packet <= w.first;
					laser_index <= w.idx; vert_angle_cdeg <= w.vert; rot_corr_cdeg <= w.rot;
					dist_corr_mm <= w.dcorr; vert_offset_mm <= w.voff;
					horiz_offset_mm <= w.hoff; laser_enable <= w.en;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (400) @(posedge clk);
		hold_on <= 1'b0;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				point_t p;
				n_points++;
				if (points_due.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected point laser %0d", laser_number);
				end else begin
					p = points_due.pop_front();
					if (p.fwd !== coord_forward_mm || p.up !== coord_up_mm
						|| p.back !== coord_back_mm || p.laser !== laser_number
						|| p.inten !== return_intensity) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp %0d %0d %0d L%0d I%0d got %0d %0d %0d L%0d I%0d",
								p.fwd, p.up, p.back, p.laser, p.inten, coord_forward_mm,
								coord_up_mm, coord_back_mm, laser_number, return_intensity);
					end
				end
			end
			if (hold_on) begin
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall) begin
				mon_wait <= $urandom_range(0, 4);
				out_stall <= 1'b0;
			end else if (mon_wait > 0 && !run_done) begin
				mon_wait <= mon_wait - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			if (idle_cycles > 20000) begin
				$display("FAIL lidar_packet_to_points");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending.size() > 0 || in_valid || points_due.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] v);
		@(posedge clk);
		wr_en <= 1'b1; wr_index <= idx; wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_RANGE_MIN) pr_min = v; else pr_max = v;
	endtask

	initial begin
		pr_min = RANGE_MIN_RESET; pr_max = RANGE_MAX_RESET;
		pos = 0; bank_upper = 0; blk_rot = 0; part = 0;
		for (int i = 0; i < 64; i++) cal_en[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: calibrations for every laser, extreme for lasers 0 to 3, then one packet at reset ranges
		for (int i = 0; i < 64; i++) pending = {pending, cal_word(i, i >= 4, i != 5)};
		queue_packet(2, 32, 1'b0, 1'b0);
		wait_drained();
		write_reg(REG_RANGE_MIN, 16'd0);
		write_reg(REG_RANGE_MAX, 16'hFFFF);
		// back pressure while bytes keep coming
		hold_go = 1;
		queue_packet(2, 32, 1'b0, 1'b0);
		wait_drained();
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_RANGE_MIN, ph == 3 ? 16'hFFFF : 16'($urandom_range(0, 3000)));
			write_reg(REG_RANGE_MAX, ph == 2 ? 16'd0 : 16'($urandom_range(30000, 65535)));
			for (int i = 0; i < 8; i++)
				pending = {pending,
					cal_word($urandom_range(0, 63), 1'b1, $urandom_range(0, 3) != 0)};
			queue_packet(1, $urandom_range(1, 32), 1'b0, 1'b0);
			wait_drained();
		end
		write_reg(REG_RANGE_MIN, 16'd1100);
		write_reg(REG_RANGE_MAX, 16'd60000);
		wait_drained();
		run_done = 1;
		repeat (100) @(posedge clk);
		$display("Covered %0d words, %0d points; range extremes, bank headers, long stall.",
			n_words, n_points);
		if (errors == 0 && points_due.size() == 0) begin
			$display("PASS lidar_packet_to_points");
		end else begin
			$display("FAIL lidar_packet_to_points");
		end
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lpp_pkg.sv
rtl/core/lpp_ram.sv
rtl/core/lpp_datapath.sv
rtl/core/lpp_ctrl.sv
rtl/core/lidar_packet_to_points.sv
verif/tb.sv
